[src/unicode_token_lexer_macros.svh]
// Assertion macros used by the lexer top module.
`ifndef UNICODE_TOKEN_LEXER_MACROS_SVH
`define UNICODE_TOKEN_LEXER_MACROS_SVH

// Label, clock, reset, property expression and message.
`define UTL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define UTL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/utl_pkg.sv]
package utl_pkg;

    localparam int CP_W = 21;

    typedef enum logic [3:0] {
        M_IDLE      = 4'd0,
        M_COMMENT   = 4'd1,
        M_STR       = 4'd2,
        M_STR_SKIP  = 4'd3,
        M_NUM_INT   = 4'd4,
        M_NUM_FRAC  = 4'd5,
        M_NUM_ESIGN = 4'd6,
        M_NUM_EXP   = 4'd7,
        M_OP_EQ     = 4'd8,
        M_OP_BANG   = 4'd9,
        M_OP_LT     = 4'd10,
        M_OP_GT     = 4'd11,
        M_SYMBOL    = 4'd12
    } lex_mode_t;

    typedef enum logic [2:0] {
        K_NUM  = 3'd0,
        K_STR  = 3'd1,
        K_SYM  = 3'd2,
        K_OP   = 3'd3,
        K_SPEC = 3'd4
    } kind_t;

    typedef logic [CP_W-1:0] cp_t;

    // One emitted character, before position is attached.
    typedef struct packed {
        logic  valid;
        cp_t   ch;
        logic  first;
        kind_t kind;
        logic  starts;
    } emit_t;

    function automatic logic is_ws(input cp_t c);
        if (c <= cp_t'(127)) begin
            return c == cp_t'(32) || (c >= cp_t'(9) && c <= cp_t'(13));
        end
        return (c >= cp_t'('h2000) && c <= cp_t'('h200B)) || c == cp_t'('h00A0)
            || c == cp_t'('h1680) || c == cp_t'('h180E) || c == cp_t'('h2028)
            || c == cp_t'('h2029) || c == cp_t'('h202F) || c == cp_t'('h205F)
            || c == cp_t'('h3000) || c == cp_t'('hFEFF);
    endfunction

    function automatic logic is_numeral(input cp_t c);
        return c >= cp_t'(48) && c <= cp_t'(57);
    endfunction

    function automatic logic is_op(input cp_t c);
        logic r;
        unique case (c)
            cp_t'("+"), cp_t'("-"), cp_t'("*"), cp_t'("/"), cp_t'("="),
            cp_t'("<"), cp_t'(">"), cp_t'("!"), cp_t'("%"), cp_t'("^"),
            cp_t'("&"), cp_t'("|"), cp_t'("("), cp_t'(")"), cp_t'("["),
            cp_t'("]"), cp_t'("{"), cp_t'("}"), cp_t'(","), cp_t'(";"): r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_special(input cp_t c);
        logic r;
        if ((c >= cp_t'('h391) && c <= cp_t'('h3A1)) || (c >= cp_t'('h3A3)
            && c <= cp_t'('h3A9)) || (c >= cp_t'('h3B1) && c <= cp_t'('h3C9))) begin
            return 1'b1;
        end
        unique case (c)
            cp_t'('h221E), cp_t'('h2205), cp_t'('h2208), cp_t'('h2209),
            cp_t'('h222A), cp_t'('h2229), cp_t'('h2286), cp_t'('h2282),
            cp_t'('h2287), cp_t'('h2283), cp_t'('h2200), cp_t'('h2203),
            cp_t'('h2204), cp_t'('h2234), cp_t'('h2235), cp_t'('h2261),
            cp_t'('h2260), cp_t'('h2248), cp_t'('h2264), cp_t'('h2265),
            cp_t'('h00B1), cp_t'('h2213), cp_t'('h00D7), cp_t'('h00F7),
            cp_t'('h221A), cp_t'('h221B), cp_t'('h221C), cp_t'('h221D),
            cp_t'('h27E8), cp_t'('h27E9), cp_t'('h007C), cp_t'('h2297),
            cp_t'('h2295), cp_t'('h2020), cp_t'('h230A), cp_t'('h230B),
            cp_t'('h2308), cp_t'('h2309), cp_t'('h3010), cp_t'('h3011),
            cp_t'('h3016), cp_t'('h3017): r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

[src/utl_classify.sv]
// Classifies one character in the current mode, with one character of lookahead.
// starts is set when the character opens a token (token position is taken).
module utl_classify
    import utl_pkg::*;
(
    input  lex_mode_t mode_in,
    input  cp_t       c,
    input  logic      has_next,
    input  cp_t       nx,
    output lex_mode_t mode_out,
    output emit_t     em
);

    logic ext;
    logic handled;
    logic nx_digit;

    assign nx_digit = has_next && is_numeral(nx);

    always_comb begin
        ext = 1'b0;
        handled = 1'b0;
        mode_out = mode_in;
        em = '0;
        unique case (mode_in)
            M_COMMENT: begin
                handled = 1'b1;
                if (c == cp_t'(10)) mode_out = M_IDLE;
            end
            M_STR: begin
                handled = 1'b1;
                em.valid = 1'b1;
                em.kind = K_STR;
                em.ch = c;
                if (c == cp_t'(34)) begin
                    mode_out = M_IDLE;
                end else if (c == cp_t'(92) && has_next && nx == cp_t'(34)) begin
                    em.ch = cp_t'(34);
                    mode_out = M_STR_SKIP;
                end
            end
            M_STR_SKIP: begin
                handled = 1'b1;
                mode_out = M_STR;
            end
            M_NUM_INT: begin
                if (is_numeral(c)) begin
                    ext = 1'b1;
                end else if (c == cp_t'(46) && nx_digit) begin
                    ext = 1'b1;
                    mode_out = M_NUM_FRAC;
                end else if (c == cp_t'(101) || c == cp_t'(69)) begin
                    ext = 1'b1;
                    mode_out = M_NUM_ESIGN;
                end
            end
            M_NUM_FRAC: begin
                if (is_numeral(c)) begin
                    ext = 1'b1;
                end else if (c == cp_t'(101) || c == cp_t'(69)) begin
                    ext = 1'b1;
                    mode_out = M_NUM_ESIGN;
                end
            end
            M_NUM_ESIGN: begin
                if (c == cp_t'(43) || c == cp_t'(45) || is_numeral(c)) begin
                    ext = 1'b1;
                    mode_out = M_NUM_EXP;
                end
            end
            M_NUM_EXP: ext = is_numeral(c);
            M_OP_EQ, M_OP_BANG: handled = (c == cp_t'(61));
            M_OP_LT: handled = (c == cp_t'(61) || c == cp_t'(60));
            M_OP_GT: handled = (c == cp_t'(61) || c == cp_t'(62));
            M_SYMBOL: handled = !is_ws(c) && !is_op(c) && c != cp_t'(34)
                && c != cp_t'(35);
            default: ;
        endcase

        // Second characters of operators and continued symbols.
        if (handled && (mode_in == M_OP_EQ || mode_in == M_OP_BANG
            || mode_in == M_OP_LT || mode_in == M_OP_GT)) begin
            em.valid = 1'b1;
            em.ch = c;
            em.kind = K_OP;
            mode_out = M_IDLE;
        end else if (handled && mode_in == M_SYMBOL) begin
            em.valid = 1'b1;
            em.ch = c;
            em.kind = K_SYM;
        end

        if (ext) begin
            em.valid = 1'b1;
            em.ch = c;
            em.kind = K_NUM;
        end else if (!handled) begin
            // The character closes whatever was open and starts afresh.
            mode_out = M_IDLE;
            em = '0;
            em.ch = c;
            em.first = 1'b1;
            if (is_ws(c)) begin
                em.ch = c;
            end else if (c == cp_t'(35) || (c == cp_t'(47) && has_next
                && nx == cp_t'(47))) begin
                mode_out = M_COMMENT;
            end else begin
                em.valid = 1'b1;
                em.starts = 1'b1;
                if (c == cp_t'(34)) begin
                    em.kind = K_STR;
                    mode_out = M_STR;
                end else if (is_numeral(c) || (c == cp_t'(45) && nx_digit)) begin
                    em.kind = K_NUM;
                    mode_out = M_NUM_INT;
                end else if (is_special(c)) begin
                    em.kind = K_SPEC;
                end else if (is_op(c)) begin
                    em.kind = K_OP;
                    if (c == cp_t'(61)) mode_out = M_OP_EQ;
                    else if (c == cp_t'(33)) mode_out = M_OP_BANG;
                    else if (c == cp_t'(60)) mode_out = M_OP_LT;
                    else if (c == cp_t'(62)) mode_out = M_OP_GT;
                end else begin
                    em.kind = K_SYM;
                    mode_out = M_SYMBOL;
                end
            end
        end
    end

endmodule

[src/unicode_token_lexer.sv]
// Channel | Dir | Fields
// s_axis  | in  | tdata: code_point[20:0]; tlast: end_of_source
// m_axis  | out | tdata: char_out, kind, line, column; tuser: token_first; tlast: stream_done
//
// A code point is classified when its successor arrives; its result is registered into the
// output queue on that transfer. One code point per cycle is sustained while m_axis_tready
// is high. An end-of-source transfer can yield two results, which fill both output entries.
// s_axis_tready is high when the two-entry output queue is empty, or holds one result
// that is taken in the same cycle; otherwise the input stalls.
// aresetn is synchronous, active low; afterwards line and column are 1.
`include "unicode_token_lexer_macros.svh"
module unicode_token_lexer
    import utl_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // code_point[20:0], zero fill
    input  logic        s_axis_tlast,  // end_of_source
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // char_out[20:0], token_kind[23:21],
                                       // tok_line[39:24], tok_col[55:40]
    output logic        m_axis_tuser,  // token_first
    output logic        m_axis_tlast   // stream_done
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    typedef logic [POSITION_BITS-1:0] pos_t;

    typedef struct packed {
        cp_t         ch;
        logic        first;
        kind_t       kind;
        logic [15:0] line;
        logic [15:0] col;
        logic        done;
    } res_t;

    logic      held_valid_reg;
    cp_t       held_char_reg;
    lex_mode_t mode_reg;
    pos_t      cur_line_reg, cur_col_reg, tok_line_reg, tok_col_reg;
    pos_t      held_line_reg, held_col_reg;

    res_t      q_reg [2];
    logic [1:0] cnt_reg;

    cp_t       in_c;
    logic      in_eos, acc;
    lex_mode_t mode_a, mode_b, mode_a_in;
    emit_t     em_a, em_b;
    pos_t      tl_a, tc_a, tl_b, tc_b;
    pos_t      nline, ncol;
    res_t      r0, r1;
    logic [1:0] n_res;

    assign in_c = s_axis_tdata[CP_W-1:0];
    assign in_eos = s_axis_tlast;
    assign s_axis_tready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_axis_tready);
    assign acc = s_axis_tvalid && s_axis_tready;

    assign mode_a_in = held_valid_reg ? mode_reg : M_IDLE;

    utl_classify u_cls_a (
        .mode_in(mode_a_in), .c(held_char_reg), .has_next(1'b1), .nx(in_c),
        .mode_out(mode_a), .em(em_a)
    );

    utl_classify u_cls_b (
        .mode_in(held_valid_reg ? mode_a : mode_reg), .c(in_c), .has_next(1'b0),
        .nx('0), .mode_out(mode_b), .em(em_b)
    );

    always_comb begin
        emit_t ea;
        ea = held_valid_reg ? em_a : emit_t'('0);
        tl_a = (ea.valid && ea.starts) ? held_line_reg : tok_line_reg;
        tc_a = (ea.valid && ea.starts) ? held_col_reg : tok_col_reg;
        tl_b = (em_b.valid && em_b.starts) ? cur_line_reg : tl_a;
        tc_b = (em_b.valid && em_b.starts) ? cur_col_reg : tc_a;

        if (in_c == cp_t'(10)) begin
            nline = (cur_line_reg < POS_MAX) ? cur_line_reg + POS_ONE : cur_line_reg;
            ncol = POS_ONE;
        end else begin
            nline = cur_line_reg;
            ncol = (cur_col_reg < POS_MAX) ? cur_col_reg + POS_ONE : cur_col_reg;
        end

        r0 = '0;
        r1 = '0;
        n_res = 2'd0;
        if (ea.valid) begin
            r0 = '{ch: ea.ch, first: ea.first, kind: ea.kind,
                   line: 16'(tl_a), col: 16'(tc_a), done: 1'b0};
            n_res = 2'd1;
        end
        if (in_eos) begin
            if (em_b.valid) begin
                if (ea.valid) begin
                    r1 = '{ch: em_b.ch, first: em_b.first, kind: em_b.kind,
                           line: 16'(tl_b), col: 16'(tc_b), done: 1'b1};
                    n_res = 2'd2;
                end else begin
                    r0 = '{ch: em_b.ch, first: em_b.first, kind: em_b.kind,
                           line: 16'(tl_b), col: 16'(tc_b), done: 1'b1};
                    n_res = 2'd1;
                end
            end else if (ea.valid) begin
                r0.done = 1'b1;
            end else begin
                r0.done = 1'b1;
                n_res = 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        logic [1:0] c;
        res_t q0, q1;
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            held_char_reg <= '0;
            mode_reg <= M_IDLE;
            cur_line_reg <= POS_ONE;
            cur_col_reg <= POS_ONE;
            tok_line_reg <= POS_ONE;
            tok_col_reg <= POS_ONE;
            held_line_reg <= POS_ONE;
            held_col_reg <= POS_ONE;
            cnt_reg <= 2'd0;
        end else begin
            c = cnt_reg;
            q0 = q_reg[0];
            q1 = q_reg[1];
            if (m_axis_tvalid && m_axis_tready) begin
                q0 = q1;
                c = c - 2'd1;
            end
            if (acc) begin
                if (n_res == 2'd2) begin
                    q0 = r0;
                    q1 = r1;
                end else if (n_res == 2'd1) begin
                    if (c == 2'd0) q0 = r0;
                    else q1 = r0;
                end
                c = c + n_res;
                if (in_eos) begin
                    held_valid_reg <= 1'b0;
                    held_char_reg <= '0;
                    mode_reg <= M_IDLE;
                    cur_line_reg <= POS_ONE;
                    cur_col_reg <= POS_ONE;
                    tok_line_reg <= POS_ONE;
                    tok_col_reg <= POS_ONE;
                    held_line_reg <= POS_ONE;
                    held_col_reg <= POS_ONE;
                end else begin
                    held_valid_reg <= 1'b1;
                    held_char_reg <= in_c;
                    held_line_reg <= cur_line_reg;
                    held_col_reg <= cur_col_reg;
                    mode_reg <= held_valid_reg ? mode_a : mode_reg;
                    tok_line_reg <= tl_a;
                    tok_col_reg <= tc_a;
                    cur_line_reg <= nline;
                    cur_col_reg <= ncol;
                end
            end
            q_reg[0] <= q0;
            q_reg[1] <= q1;
            cnt_reg <= c;
        end
    end

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata = {q_reg[0].col, q_reg[0].line, q_reg[0].kind, q_reg[0].ch};
    assign m_axis_tuser = q_reg[0].first;
    assign m_axis_tlast = q_reg[0].done;

    `UTL_ASSERT(a_cnt_range, aclk, aresetn, cnt_reg != 2'd3, "output queue overflow")
    `UTL_ASSERT_NEXT(a_eos_clears, aclk, aresetn, acc && in_eos, !held_valid_reg, "held char after end")
    `UTL_ASSERT(a_pos_nonzero, aclk, aresetn, cur_line_reg != '0 && cur_col_reg != '0, "position zero")

endmodule
